>>> rtl/fvai_pkg.sv
// Shared types, opcodes and saturation helpers for the four-lane vector ALU.
// No dependencies.
package fvai_pkg;

  localparam int LANES = 4;
  localparam int DIV_BPS = 4;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_ADDS   = 4'd4,
    OP_SUBS   = 4'd5,
    OP_MULS   = 4'd6,
    OP_DIVS   = 4'd7,
    OP_LERP   = 4'd8,
    OP_CUBIC  = 4'd9,
    OP_COSINE = 4'd10
  } op_e;

  typedef struct packed {
    logic signed [31:0] w1;
    logic signed [31:0] w2;
  } wgt_t;

  typedef struct packed {
    logic signed [31:0] r;
    logic               ovf;
    logic               dz;
  } lane_res_t;

  function automatic logic sat_ovf(input logic signed [67:0] v);
    return (v > 68'(Q_MAX)) || (v < 68'(Q_MIN));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < 68'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/four_lane_vector_alu_interp.sv
// Top level of the four-lane Q16.16 vector ALU with interpolation.
// Depends on fvai_pkg, fvai_wgt and fvai_lane.
//
// Takes one transfer per clock while in_stall_o is low and returns one result per transfer, in order.
// DS = ceil((32+FRAC_BITS)/4) is the number of radix-16 divider stages;
// all opcodes share the same pipeline depth. Each pipeline stage holds
// only while the stage ahead of it is full and stalled, so bubbles close
// up and a waiting result blocks new input only once every stage is full.
module four_lane_vector_alu_interp import fvai_pkg::*; #(
  parameter int FRAC_BITS       = 16,
  parameter int COS_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         opcode_i,
  input  logic signed [31:0] a_lane0_i,
  input  logic signed [31:0] a_lane1_i,
  input  logic signed [31:0] a_lane2_i,
  input  logic signed [31:0] a_lane3_i,
  input  logic signed [31:0] b_lane0_i,
  input  logic signed [31:0] b_lane1_i,
  input  logic signed [31:0] b_lane2_i,
  input  logic signed [31:0] b_lane3_i,
  input  logic signed [31:0] scalar_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] r_lane0_o,
  output logic signed [31:0] r_lane1_o,
  output logic signed [31:0] r_lane2_o,
  output logic signed [31:0] r_lane3_o,
  output logic               overflow_flag_o,
  output logic               divzero_flag_o
);

  localparam int DS = (32 + FRAC_BITS + DIV_BPS - 1) / DIV_BPS;
  localparam int LAST = DS + 2;

  logic [LAST:0] v_q, v_d, en;

  assign en[LAST] = !v_q[LAST] || !out_stall_i;
  for (genvar k = 0; k < LAST; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k <= LAST; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[LAST];

  // input register stage
  logic signed [31:0] a_in [LANES];
  logic signed [31:0] b_in [LANES];
  logic signed [31:0] a0_q [LANES];
  logic signed [31:0] b0_q [LANES];
  logic [3:0]         op0_q;
  logic signed [31:0] s0_q;

  assign a_in = '{a_lane0_i, a_lane1_i, a_lane2_i, a_lane3_i};
  assign b_in = '{b_lane0_i, b_lane1_i, b_lane2_i, b_lane3_i};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op0_q <= opcode_i;
      s0_q  <= scalar_i;
      a0_q  <= a_in;
      b0_q  <= b_in;
    end
  end

  wgt_t      wgt;
  logic      wovf;
  lane_res_t res [LANES];

  fvai_wgt #(
    .FRAC_BITS      (FRAC_BITS),
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH),
    .LAST           (LAST)
  ) u_wgt (
    .clk_i(clk_i),
    .en_i (en[LAST:1]),
    .op_i (op0_q),
    .s_i  (s0_q),
    .wgt_o(wgt),
    .ovf_o(wovf)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    fvai_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i(clk_i),
      .en_i (en[LAST:1]),
      .op_i (op0_q),
      .a_i  (a0_q[l]),
      .b_i  (b0_q[l]),
      .s_i  (s0_q),
      .wgt_i(wgt),
      .res_o(res[l])
    );
  end

  assign r_lane0_o       = res[0].r;
  assign r_lane1_o       = res[1].r;
  assign r_lane2_o       = res[2].r;
  assign r_lane3_o       = res[3].r;
  assign overflow_flag_o = wovf | res[0].ovf | res[1].ovf | res[2].ovf | res[3].ovf;
  assign divzero_flag_o  = res[0].dz | res[1].dz | res[2].dz | res[3].dz;

endmodule

>>> rtl/fvai_wgt.sv
// Blend weight pipeline: cubic Hermite weights and cosine table lookup.
// Depends on fvai_pkg.
module fvai_wgt import fvai_pkg::*; #(
  parameter int FRAC_BITS       = 16,
  parameter int COS_TABLE_DEPTH = 256,
  parameter int LAST            = 14
) (
  input  logic               clk_i,
  input  logic [LAST:1]      en_i,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] s_i,
  output wgt_t               wgt_o,
  output logic               ovf_o
);

  localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int PW = FRAC_BITS + IW;
  localparam int TW = FRAC_BITS + 1;
  localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [67:0] ONE = 68'sd1 <<< FRAC_BITS;
  localparam logic [TW:0] TWO_ONE = (TW+1)'(1) << TW;
  localparam logic [TW-1:0] ONE_U = TW'(1) << FRAC_BITS;

  function automatic logic [FRAC_BITS:0] cos_entry(input int unsigned k);
    logic [63:0] x, x2, mag;
    logic signed [63:0] sum, f;
    logic neg;
    x = (PI_Q30 * 64'(k)) / 64'(COS_TABLE_DEPTH);
    neg = 1'b0;
    if (x > (PI_Q30 >> 1)) begin
      x = PI_Q30 - x;
      neg = 1'b1;
    end
    x2 = (x * x) >> 30;
    mag = 64'd1 << 30;
    sum = 64'sd1 <<< 30;
    for (int n = 1; n <= 10; n++) begin
      mag = ((mag * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n[0]) begin
        sum = sum - $signed(mag);
      end else begin
        sum = sum + $signed(mag);
      end
    end
    if (neg) begin
      sum = -sum;
    end
    f = (64'sd1 <<< 30) - sum;
    if (f < 0) begin
      f = 64'sd0;
    end
    if (f > (64'sd1 <<< 31)) begin
      f = 64'sd1 <<< 31;
    end
    f = (f + (64'sd1 <<< (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
    return f[FRAC_BITS:0];
  endfunction

  function automatic logic signed [67:0] rnd(input logic signed [67:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  logic [TW-1:0] cos_rom [COS_TABLE_DEPTH+1];

  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
    assign cos_rom[k] = cos_entry(k);
  end

  // stage 1
  logic [3:0]           op1_q;
  logic signed [31:0]   s1_q;
  logic signed [63:0]   ss1_q;
  logic [IW-1:0]        idx1_q;
  logic [FRAC_BITS-1:0] fr1_q;
  logic [TW-1:0]        u1, t1;
  logic [PW-1:0]        p1;

  always_comb begin
    u1 = s_i[FRAC_BITS:0];
    t1 = (u1 > ONE_U) ? TW'(TWO_ONE - (TW+1)'(u1)) : u1;
    p1 = PW'(t1) * PW'(COS_TABLE_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      op1_q  <= op_i;
      s1_q   <= s_i;
      ss1_q  <= s_i * s_i;
      idx1_q <= p1[PW-1:FRAC_BITS];
      fr1_q  <= p1[FRAC_BITS-1:0];
    end
  end

  // stage 2
  logic [3:0]           op2_q;
  logic signed [31:0]   s2v_q, s2_q;
  logic                 ovf2_q;
  logic [TW-1:0]        lo2_q, hi2_q;
  logic [FRAC_BITS-1:0] fr2_q;
  logic [IW-1:0]        idx_c;
  logic                 idx_in;
  logic signed [67:0]   rss;

  always_comb begin
    idx_in = idx1_q < IW'(COS_TABLE_DEPTH);
    idx_c  = idx_in ? idx1_q : IW'(COS_TABLE_DEPTH);
    rss    = rnd(68'(ss1_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      op2_q  <= op1_q;
      s2v_q  <= s1_q;
      s2_q   <= sat32(rss);
      ovf2_q <= sat_ovf(rss);
      lo2_q  <= cos_rom[idx_c];
      hi2_q  <= cos_rom[idx_in ? idx_c + IW'(1) : idx_c];
      fr2_q  <= idx_in ? fr1_q : '0;
    end
  end

  // stage 3
  logic [3:0]                  op3_q;
  logic signed [31:0]          s2_3_q;
  logic signed [63:0]          p3_q;
  logic                        ovf3_q;
  logic [TW-1:0]               lo3_q;
  logic signed [2*TW+1:0]      dp3_q;
  logic signed [TW:0]          dlt;

  assign dlt = $signed({1'b0, hi2_q}) - $signed({1'b0, lo2_q});

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      op3_q  <= op2_q;
      s2_3_q <= s2_q;
      p3_q   <= s2_q * s2v_q;
      ovf3_q <= ovf2_q;
      lo3_q  <= lo2_q;
      dp3_q  <= (2*TW+2)'(dlt) * $signed((2*TW+2)'({1'b0, fr2_q}));
    end
  end

  // stage 4
  logic [3:0]         op4_q;
  logic signed [31:0] w2_4_q;
  logic               ovf4_q;
  logic signed [67:0] r3, w2c;
  logic signed [31:0] s3;
  logic signed [67:0] w2cos;

  always_comb begin
    r3    = rnd(68'(p3_q));
    s3    = sat32(r3);
    w2c   = 68'sd3 * 68'(s2_3_q) - 68'sd2 * 68'(s3);
    w2cos = 68'($signed({1'b0, lo3_q})) + (68'(dp3_q) >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      op4_q <= op3_q;
      if (op3_q == OP_CUBIC) begin
        w2_4_q <= sat32(w2c);
        ovf4_q <= ovf3_q | sat_ovf(r3) | sat_ovf(w2c);
      end else begin
        w2_4_q <= w2cos[31:0];
        ovf4_q <= 1'b0;
      end
    end
  end

  // stage 5 and flag carry
  logic signed [67:0] w1v;
  logic               ovf_q [LAST:5];

  assign w1v = ONE - 68'(w2_4_q);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      wgt_o.w1 <= sat32(w1v);
      wgt_o.w2 <= w2_4_q;
      ovf_q[5] <= ovf4_q | ((op4_q == OP_CUBIC) & sat_ovf(w1v));
    end
  end

  for (genvar k = 6; k <= LAST; k++) begin : g_ovf
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign ovf_o = ovf_q[LAST];

endmodule

>>> rtl/fvai_lane.sv
// One lane: add/sub, multiply, lerp and blend datapath plus a pipelined divider.
// Depends on fvai_pkg.
module fvai_lane import fvai_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic [((32+FRAC_BITS+DIV_BPS-1)/DIV_BPS)+2:1] en_i,
  input  logic [3:0]                    op_i,
  input  logic signed [31:0]            a_i,
  input  logic signed [31:0]            b_i,
  input  logic signed [31:0]            s_i,
  input  wgt_t                          wgt_i,
  output lane_res_t                     res_o
);

  localparam int DS = (32 + FRAC_BITS + DIV_BPS - 1) / DIV_BPS;
  localparam int QB = DS * DIV_BPS;
  localparam int LAST = DS + 2;
  localparam logic signed [67:0] HALF = 68'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] y;
    logic signed [31:0] s;
    logic signed [32:0] d;
  } opnd_t;

  typedef struct packed {
    logic [32:0]   rem;
    logic [QB-1:0] num;
    logic [31:0]   dmag;
    logic          qneg;
    logic          dz;
    logic          aneg;
    logic          anz;
    logic          isdiv;
  } div_t;

  typedef struct packed {
    logic signed [31:0] r;
    logic               ovf;
  } ares_t;

  function automatic logic signed [67:0] rnd(input logic signed [67:0] x);
    return (x + HALF) >>> FRAC_BITS;
  endfunction

  opnd_t opnd_q [6:1];
  div_t  div_q  [LAST-1:1];
  ares_t ar_q   [LAST-1:7];

  // stage 1: operand select and divider setup
  logic               scal;
  logic signed [31:0] y1;
  logic [31:0]        amag, ymag;

  always_comb begin
    scal = (op_i >= OP_ADDS) && (op_i <= OP_DIVS);
    y1   = scal ? s_i : b_i;
    amag = a_i[31] ? 32'(-a_i) : 32'(a_i);
    ymag = y1[31] ? 32'(-y1) : 32'(y1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      opnd_q[1]       <= '{op: op_i, a: a_i, y: y1, s: s_i, d: 33'(b_i) - 33'(a_i)};
      div_q[1].rem    <= '0;
      div_q[1].num    <= QB'(amag) << FRAC_BITS;
      div_q[1].dmag   <= ymag;
      div_q[1].qneg   <= a_i[31] ^ y1[31];
      div_q[1].dz     <= y1 == 32'sd0;
      div_q[1].aneg   <= a_i[31];
      div_q[1].anz    <= a_i != 32'sd0;
      div_q[1].isdiv  <= (op_i == OP_DIV) || (op_i == OP_DIVS);
    end
  end

  for (genvar k = 2; k <= 6; k++) begin : g_opnd
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        opnd_q[k] <= opnd_q[k-1];
      end
    end
  end

  // radix-16 restoring divide stages
  for (genvar j = 2; j <= LAST - 1; j++) begin : g_div
    div_t nx;
    always_comb begin
      nx = div_q[j-1];
      for (int i = 0; i < DIV_BPS; i++) begin
        nx.rem = {nx.rem[31:0], nx.num[QB-1]};
        nx.num = nx.num << 1;
        if (nx.rem >= {1'b0, nx.dmag}) begin
          nx.rem    = nx.rem - {1'b0, nx.dmag};
          nx.num[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        div_q[j] <= nx;
      end
    end
  end

  // stage 6: multiplies
  logic signed [32:0] x1, x2;
  logic signed [65:0] m1_q, m2_q;
  opnd_t              o5;

  always_comb begin
    o5 = opnd_q[5];
    if (o5.op == OP_LERP) begin
      x1 = 33'(o5.s);
      x2 = o5.d;
    end else if ((o5.op == OP_MUL) || (o5.op == OP_MULS)) begin
      x1 = 33'(o5.a);
      x2 = 33'(o5.y);
    end else begin
      x1 = 33'(o5.a);
      x2 = 33'(wgt_i.w1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      m1_q <= 66'(x1) * 66'(x2);
      m2_q <= 66'(o5.y) * 66'(wgt_i.w2);
    end
  end

  // stage 7: combine and saturate
  logic signed [67:0] v7;
  logic               use7;
  opnd_t              o6;

  always_comb begin
    o6   = opnd_q[6];
    use7 = 1'b1;
    case (o6.op) inside
      OP_ADD, OP_ADDS:     v7 = 68'(o6.a) + 68'(o6.y);
      OP_SUB, OP_SUBS:     v7 = 68'(o6.a) - 68'(o6.y);
      OP_MUL, OP_MULS:     v7 = rnd(68'(m1_q));
      OP_LERP:             v7 = 68'(o6.a) + rnd(68'(m1_q));
      OP_CUBIC, OP_COSINE: v7 = rnd(68'(m1_q) + 68'(m2_q));
      default: begin
        v7   = '0;
        use7 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      ar_q[7].r   <= sat32(v7);
      ar_q[7].ovf <= use7 & sat_ovf(v7);
    end
  end

  for (genvar k = 8; k <= LAST - 1; k++) begin : g_ar
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        ar_q[k] <= ar_q[k-1];
      end
    end
  end

  // final stage: result select, quotient sign, divide-by-zero and saturation
  div_t      dl;
  lane_res_t fin;

  always_comb begin
    dl = div_q[LAST-1];
    if (!dl.isdiv) begin
      fin = '{r: ar_q[LAST-1].r, ovf: ar_q[LAST-1].ovf, dz: 1'b0};
    end else if (dl.dz) begin
      fin.r   = dl.anz ? (dl.aneg ? Q_MIN : Q_MAX) : 32'sd0;
      fin.ovf = 1'b0;
      fin.dz  = 1'b1;
    end else if (!dl.qneg) begin
      fin.ovf = dl.num > QB'(32'h7fff_ffff);
      fin.r   = fin.ovf ? Q_MAX : $signed(dl.num[31:0]);
      fin.dz  = 1'b0;
    end else begin
      fin.ovf = dl.num > QB'(32'h8000_0000);
      fin.r   = fin.ovf ? Q_MIN : $signed(32'(-dl.num[31:0]));
      fin.dz  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LAST]) begin
      res_o <= fin;
    end
  end

endmodule
